### rtl/core/audio_beat_tempo_detector_assert.svh
// Assertion macros for the checker file.
`ifndef AUDIO_BEAT_TEMPO_DETECTOR_ASSERT_SVH
`define AUDIO_BEAT_TEMPO_DETECTOR_ASSERT_SVH

// Checked only outside reset.
`define ABTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define ABTD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/abtd_pkg.sv
package abtd_pkg;

  localparam int HISTORY_DEPTH = 64;
  localparam int FLOOR_EXCLUDE = 4;
  localparam int GAP_DEPTH     = 8;

  localparam int MIN_FLOOR_SAMPLES = 10;
  localparam int MIN_GAPS          = 4;

  localparam int HIST_AW = $clog2(HISTORY_DEPTH);
  localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int GAP_AW  = $clog2(GAP_DEPTH);
  localparam int GC_W    = $clog2(GAP_DEPTH + 1);

  localparam int SUM_W = 16 + CNT_W;
  localparam int LHS_W = 16 + CNT_W + 8;
  localparam int RHS_W = SUM_W + 16;

  // Rounded division: round(N / d) = floor((2N + d) / 2d).
  localparam int DIV_W  = 22;
  localparam int DEN_W  = 18;
  localparam int DCNT_W = $clog2(DIV_W + 1);
  localparam logic [DIV_W-1:0] TEMPO_NUM2_ODD  = DIV_W'(1920000);
  localparam logic [DIV_W-1:0] TEMPO_NUM2_EVEN = DIV_W'(3840000);

  localparam logic [15:0] ENV_FULL  = 16'd32768;
  localparam logic [15:0] TEMPO_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    REG_THRESHOLD_MULT  = 3'd0,
    REG_MIN_RISE        = 3'd1,
    REG_MIN_LEVEL       = 3'd2,
    REG_MIN_GAP_MS      = 3'd3,
    REG_INTERVAL_MIN_MS = 3'd4,
    REG_INTERVAL_MAX_MS = 3'd5,
    REG_STALE_MS        = 3'd6,
    REG_DECAY_STEP      = 3'd7
  } reg_index_t;

endpackage

### rtl/core/audio_beat_tempo_detector.sv
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   bass_level, now_ms, elapsed_ms
// out      output     out_valid / out_ready beat, envelope, tempo_q4
// cfg      input      cfg_write             cfg_index, cfg_data
//
// Between one accepted transaction and the next, the noise floor is summed one sample-memory
// read per cycle, the median is found by ranking one stored interval per cycle, and the
// rounded tempo division is restoring, one quotient bit per cycle over 22 bits.
// Reset is synchronous; the sample memory is not cleared and needs no sweep.
// A finished result waits in the output register while the next frame is taken.
module audio_beat_tempo_detector
  import abtd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] bass_level,
  input  logic [31:0] now_ms,
  input  logic [9:0]  elapsed_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        beat,
  output logic [15:0] envelope,
  output logic [15:0] tempo_q4
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECAY, S_SUM, S_MUL, S_TEST, S_TEMPO, S_RANK, S_DIVSET, S_DIV, S_DONE
  } state_t;

  state_t state;

  logic [15:0] threshold_mult, min_rise, min_level, min_gap_ms;
  logic [15:0] interval_min_ms, interval_max_ms, stale_ms, decay_step;

  logic [15:0] sample_mem [HISTORY_DEPTH];
  logic [HIST_AW-1:0] mem_raddr;
  logic [15:0]        mem_rdata;
  logic               accept;

  logic [CNT_W-1:0]   sample_count;
  logic [HIST_AW-1:0] sample_head;
  logic [31:0]        last_beat_time;
  logic [15:0]        envelope_level;
  logic               beat_seen;
  logic [15:0]        gap_ring [GAP_DEPTH];
  logic [GC_W-1:0]    gap_count;
  logic [GAP_AW-1:0]  gap_head;

  logic [15:0] bass_q, prev_q;
  logic [31:0] now_q;
  logic [25:0] dec_q;
  logic        have_prev_q;
  logic        beat_q;

  logic [CNT_W-1:0]   window_q, issue_cnt;
  logic [HIST_AW-1:0] rd_addr;
  logic               pend;
  logic [SUM_W-1:0]   sum_q;
  logic [LHS_W-1:0]   lhs_q;
  logic [RHS_W-1:0]   rhs_q;

  logic [GAP_AW-1:0]  cand;
  logic [GC_W-1:0]    k_hi, k_lo;
  logic [15:0]        med_hi, med_lo;
  logic [GC_W-1:0]    less_cnt, le_cnt;

  logic [DIV_W-1:0]   dividend, quo;
  logic [DEN_W-1:0]   divisor;
  logic [DEN_W:0]     rem;
  logic [DCNT_W-1:0]  div_cnt;
  logic [15:0]        tempo_q;

  logic [HIST_AW-1:0] prev_addr, head_inc, rd_addr_inc;
  logic               issuing;
  logic [31:0]        since;
  logic               beat_hit, gap_fits;
  logic [16:0]        pair_sum;
  logic [DEN_W:0]     rem_shift;

  // The division leaves the counter at zero; earlier exits carry their value in tempo_q.
  function automatic logic [15:0] quo_final_sat(input logic [DIV_W-1:0] q,
                                                input logic [15:0] t,
                                                input logic [DCNT_W-1:0] c);
    logic [15:0] r;
    if (c != '0) begin
      r = t;
    end else if (q > DIV_W'(TEMPO_MAX)) begin
      r = TEMPO_MAX;
    end else begin
      r = q[15:0];
    end
    return r;
  endfunction

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);

  assign prev_addr   = (sample_head == '0) ? HIST_AW'(HISTORY_DEPTH - 1) : sample_head - 1'b1;
  assign head_inc    = (sample_head == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : sample_head + 1'b1;
  assign rd_addr_inc = (rd_addr == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : rd_addr + 1'b1;
  assign mem_raddr   = (state == S_IDLE) ? prev_addr : rd_addr;
  assign issuing     = (state == S_SUM) && (issue_cnt < window_q);

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_mem[sample_head] <= bass_level;
    end
    mem_rdata <= sample_mem[mem_raddr];
  end

  assign since    = now_q - last_beat_time;
  // The rise test first requires bass_q above prev_q, so a falling sample never passes.
  assign beat_hit = ({8'd0, lhs_q} > rhs_q) && (bass_q > prev_q) &&
                    ((bass_q - prev_q) > min_rise) && (bass_q > min_level) &&
                    (since > {16'd0, min_gap_ms});
  assign gap_fits = beat_seen && (since >= {16'd0, interval_min_ms}) &&
                    (since <= {16'd0, interval_max_ms});
  assign pair_sum = {1'b0, med_lo} + {1'b0, med_hi};
  assign rem_shift = {rem[DEN_W-1:0], dividend[DIV_W-1]};

  always_comb begin
    less_cnt = '0;
    le_cnt   = '0;
    for (int j = 0; j < GAP_DEPTH; j++) begin
      if (GC_W'(j) < gap_count) begin
        if (gap_ring[j] < gap_ring[cand]) less_cnt = less_cnt + 1'b1;
        if (gap_ring[j] <= gap_ring[cand]) le_cnt = le_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      threshold_mult  <= 16'd384;
      min_rise        <= 16'd0;
      min_level       <= 16'd0;
      min_gap_ms      <= 16'd200;
      interval_min_ms <= 16'd250;
      interval_max_ms <= 16'd2000;
      stale_ms        <= 16'd3000;
      decay_step      <= 16'd164;
      sample_count    <= '0;
      sample_head     <= '0;
      last_beat_time  <= '0;
      envelope_level  <= '0;
      beat_seen       <= 1'b0;
      gap_count       <= '0;
      gap_head        <= '0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (reg_index_t'(cfg_index))
          REG_THRESHOLD_MULT:  threshold_mult  <= cfg_data;
          REG_MIN_RISE:        min_rise        <= cfg_data;
          REG_MIN_LEVEL:       min_level       <= cfg_data;
          REG_MIN_GAP_MS:      min_gap_ms      <= cfg_data;
          REG_INTERVAL_MIN_MS: interval_min_ms <= cfg_data;
          REG_INTERVAL_MAX_MS: interval_max_ms <= cfg_data;
          REG_STALE_MS:        stale_ms        <= cfg_data;
          REG_DECAY_STEP:      decay_step      <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            bass_q      <= bass_level;
            now_q       <= now_ms;
            dec_q       <= elapsed_ms * decay_step;
            have_prev_q <= (sample_count != '0);
            sample_head <= head_inc;
            if (sample_count < CNT_W'(HISTORY_DEPTH)) begin
              sample_count <= sample_count + 1'b1;
            end
            beat_q <= 1'b0;
            state  <= S_DECAY;
          end
        end
        S_DECAY: begin
          envelope_level <= ({10'd0, envelope_level} > dec_q) ?
                            envelope_level - dec_q[15:0] : '0;
          prev_q    <= have_prev_q ? mem_rdata : '0;
          window_q  <= sample_count - CNT_W'(FLOOR_EXCLUDE);
          rd_addr   <= (sample_count < CNT_W'(HISTORY_DEPTH)) ? '0 : sample_head;
          issue_cnt <= '0;
          pend      <= 1'b0;
          sum_q     <= '0;
          state     <= (sample_count >= CNT_W'(FLOOR_EXCLUDE + MIN_FLOOR_SAMPLES)) ?
                       S_SUM : S_TEMPO;
        end
        S_SUM: begin
          if (issuing) begin
            rd_addr   <= rd_addr_inc;
            issue_cnt <= issue_cnt + 1'b1;
          end
          pend <= issuing;
          if (pend) begin
            sum_q <= sum_q + SUM_W'(mem_rdata);
          end
          if (!issuing && !pend) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          lhs_q <= (LHS_W'(bass_q) * LHS_W'(window_q)) << 8;
          rhs_q <= sum_q * threshold_mult;
          state <= S_TEST;
        end
        S_TEST: begin
          if (beat_hit) begin
            if (gap_fits) begin
              gap_ring[gap_head] <= since[15:0];
              gap_head <= (gap_head == GAP_AW'(GAP_DEPTH - 1)) ? '0 : gap_head + 1'b1;
              if (gap_count < GC_W'(GAP_DEPTH)) begin
                gap_count <= gap_count + 1'b1;
              end
            end
            last_beat_time <= now_q;
            beat_seen      <= 1'b1;
            envelope_level <= ENV_FULL;
            beat_q         <= 1'b1;
          end
          state <= S_TEMPO;
        end
        S_TEMPO: begin
          cand <= '0;
          k_hi <= gap_count >> 1;
          k_lo <= (gap_count >> 1) - 1'b1;
          if (gap_count < GC_W'(MIN_GAPS) || (now_q - last_beat_time) > {16'd0, stale_ms}) begin
            tempo_q <= '0;
            div_cnt <= DCNT_W'(DIV_W);
            state   <= S_DONE;
          end else begin
            state <= S_RANK;
          end
        end
        S_RANK: begin
          // The candidate holds sorted positions less_cnt up to le_cnt - 1.
          if (less_cnt <= k_hi && k_hi < le_cnt) med_hi <= gap_ring[cand];
          if (less_cnt <= k_lo && k_lo < le_cnt) med_lo <= gap_ring[cand];
          cand <= cand + 1'b1;
          if (GC_W'(cand) == gap_count - 1'b1) begin
            state <= S_DIVSET;
          end
        end
        S_DIVSET: begin
          rem     <= '0;
          quo     <= '0;
          div_cnt <= DCNT_W'(DIV_W);
          if (gap_count[0]) begin
            dividend <= TEMPO_NUM2_ODD + DIV_W'(med_hi);
            divisor  <= {1'b0, med_hi, 1'b0};
          end else begin
            dividend <= TEMPO_NUM2_EVEN + DIV_W'(pair_sum);
            divisor  <= {pair_sum, 1'b0};
          end
          if (gap_count[0] ? (med_hi == '0) : (pair_sum == '0)) begin
            tempo_q <= TEMPO_MAX;
            state   <= S_DONE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          dividend <= dividend << 1;
          if (rem_shift >= {1'b0, divisor}) begin
            rem <= rem_shift - {1'b0, divisor};
            quo <= {quo[DIV_W-2:0], 1'b1};
          end else begin
            rem <= rem_shift;
            quo <= {quo[DIV_W-2:0], 1'b0};
          end
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == DCNT_W'(1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            beat      <= beat_q;
            envelope  <= envelope_level;
            tempo_q4  <= (quo_final_sat(quo, tempo_q, div_cnt));
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/abtd_checker.sv
module abtd_checker
  import abtd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        beat,
  input logic [15:0] envelope,
  input logic [15:0] tempo_q4
);

`include "audio_beat_tempo_detector_assert.svh"

  `ABTD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(beat) && $stable(envelope) && $stable(tempo_q4), "stalled output transaction changed")
  `ABTD_ASSERT(a_beat_full, out_valid && beat |-> envelope == ENV_FULL, "beat without full envelope")
  `ABTD_ASSERT(a_env_range, out_valid |-> envelope <= ENV_FULL, "envelope above full scale")
  `ABTD_ASSERT(a_in_busy, in_valid && in_ready |=> !in_ready, "input taken while a frame is in flight")
  `ABTD_ASSERT_ALWAYS(a_reset_quiet, rst |=> !out_valid, "output valid right after reset")

endmodule

bind audio_beat_tempo_detector abtd_checker u_abtd_checker (.*);

### dv/audio_beat_tempo_detector_test.sv
module audio_beat_tempo_detector_test;
  import abtd_pkg::*;

  typedef struct packed {
    logic [15:0] bass;
    logic [31:0] now;
    logic [9:0]  elapsed;
  } frame_t;

  typedef struct packed {
    logic        beat;
    logic [15:0] env;
    logic [15:0] tempo;
  } beat_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  reg_index_t  cfg_index = REG_THRESHOLD_MULT;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] bass_level = '0;
  logic [31:0] now_ms = '0;
  logic [9:0]  elapsed_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        beat;
  logic [15:0] envelope;
  logic [15:0] tempo_q4;

  audio_beat_tempo_detector dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .bass_level(bass_level), .now_ms(now_ms), .elapsed_ms(elapsed_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .beat(beat), .envelope(envelope), .tempo_q4(tempo_q4)
  );

  // Shadow copy of the registers and the detector state.
  logic [15:0] regs [8];
  logic [15:0] hist [HISTORY_DEPTH];
  int unsigned hist_count, hist_head;
  logic [31:0] last_beat_ms;
  int unsigned env_level;
  logic [15:0] gaps [GAP_DEPTH];
  int unsigned gap_count, gap_head;
  bit          beat_seen;

  frame_t       pending_frames[$];
  beat_report_t expected_reports[$];
  int  errors = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  recv_hold = 0;
  bit  hold_request = 1'b0;
  bit  frame_taken = 1'b0;
  longint stall_cycles = 0;

  function automatic logic [15:0] rounded_tempo(longint unsigned num, longint unsigned den);
    longint unsigned q;
    if (den == 0) return TEMPO_MAX;
    q = (2 * num + den) / (2 * den);
    return (q > 65535) ? TEMPO_MAX : q[15:0];
  endfunction

  function automatic logic [15:0] median_tempo(logic [31:0] now);
    logic [15:0] sorted [GAP_DEPTH];
    logic [15:0] v;
    int unsigned n, j;
    logic [31:0] age;
    n = gap_count;
    age = now - last_beat_ms;
    if (n < MIN_GAPS || age > regs[REG_STALE_MS]) return 16'd0;
    for (int i = 0; i < n; i++) begin
      v = gaps[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    if (n % 2) return rounded_tempo(960000, sorted[n/2]);
    return rounded_tempo(1920000, longint'(sorted[n/2-1]) + sorted[n/2]);
  endfunction

  function automatic beat_report_t detect_frame(frame_t f);
    beat_report_t r;
    int unsigned dec, prev, window, start;
    longint unsigned sum;
    logic [31:0] since;
    dec = f.elapsed * regs[REG_DECAY_STEP];
    env_level = (env_level > dec) ? env_level - dec : 0;
    prev = (hist_count > 0) ? hist[(hist_head + HISTORY_DEPTH - 1) % HISTORY_DEPTH] : 0;
    hist[hist_head] = f.bass;
    hist_head = (hist_head + 1) % HISTORY_DEPTH;
    if (hist_count < HISTORY_DEPTH) hist_count++;
    r.beat = 1'b0;
    if (hist_count >= MIN_FLOOR_SAMPLES + FLOOR_EXCLUDE) begin
      window = hist_count - FLOOR_EXCLUDE;
      start = (hist_count < HISTORY_DEPTH) ? 0 : hist_head;
      sum = 0;
      for (int i = 0; i < window; i++) sum += hist[(start + i) % HISTORY_DEPTH];
      since = f.now - last_beat_ms;
      if (longint'(f.bass) * 256 * window > sum * regs[REG_THRESHOLD_MULT] &&
          longint'(f.bass) - longint'(prev) > longint'(regs[REG_MIN_RISE]) &&
          f.bass > regs[REG_MIN_LEVEL] && since > regs[REG_MIN_GAP_MS]) begin
        if (beat_seen && since >= regs[REG_INTERVAL_MIN_MS] &&
            since <= regs[REG_INTERVAL_MAX_MS]) begin
          gaps[gap_head] = since[15:0];
          gap_head = (gap_head + 1) % GAP_DEPTH;
          if (gap_count < GAP_DEPTH) gap_count++;
        end
        last_beat_ms = f.now;
        beat_seen = 1'b1;
        env_level = ENV_FULL;
        r.beat = 1'b1;
      end
    end
    r.env = env_level[15:0];
    r.tempo = median_tempo(f.now);
    return r;
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  // Driver: offers queued frames and holds each one until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || frame_taken) begin
      if (frame_taken) void'(pending_frames.pop_front());
      if (pending_frames.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid   <= 1'b1;
        bass_level <= pending_frames[0].bass;
        now_ms     <= pending_frames[0].now;
        elapsed_ms <= pending_frames[0].elapsed;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The receiver decides readiness, with a long hold-off when asked.
  always @(negedge clk) begin
    if (hold_request && recv_hold == 0) recv_hold <= 400;
    else if (recv_hold > 0) recv_hold <= recv_hold - 1;
    out_ready <= !rst && recv_hold == 0 && !hold_request &&
                 $urandom_range(99) >= recv_idle_pct;
  end

  // Monitor: predicts on each accepted frame and checks each accepted result.
  always @(posedge clk) begin
    beat_report_t got, want;
    frame_taken <= in_valid && in_ready;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (in_valid && in_ready) begin
        expected_reports.push_back(detect_frame({bass_level, now_ms, elapsed_ms}));
      end
      if (out_valid && out_ready) begin
        got = {beat, envelope, tempo_q4};
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result beat=%0d env=%0d tempo=%0d",
                   $time, beat, envelope, tempo_q4);
          errors++;
        end else begin
          want = expected_reports.pop_front();
          if (got.beat !== want.beat) begin
            $display("%0t: beat expected %0d actual %0d", $time, want.beat, got.beat);
            errors++;
          end
          if (got.env !== want.env) begin
            $display("%0t: envelope expected %0d actual %0d", $time, want.env, got.env);
            errors++;
          end
          if (got.tempo !== want.tempo) begin
            $display("%0t: tempo expected %0d actual %0d", $time, want.tempo, got.tempo);
            errors++;
          end
        end
      end
      if (stall_cycles > 20000) begin
        $display("[audio_beat_tempo_detector] ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_index_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    regs[idx] = val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain;
    wait (pending_frames.size() == 0 && !in_valid && expected_reports.size() == 0);
    repeat (150) @(posedge clk);
  endtask

  // Rhythmic pulses over a quiet bed, random content and spacing.
  task automatic queue_rhythm(int count, ref logic [31:0] t);
    int period, step;
    period = $urandom_range(250, 900);
    step = $urandom_range(5, 60);
    for (int i = 0; i < count; i++) begin
      frame_t f;
      f.elapsed = step[9:0];
      t += step;
      f.now = t;
      if ((t % period) < step) f.bass = 16'($urandom_range(20000, 65535));
      else f.bass = 16'($urandom_range(0, 3000));
      if ($urandom_range(99) < 8) f.bass = 16'($urandom);
      if ($urandom_range(99) < 4) begin
        f.elapsed = 10'($urandom);
        f.now = $urandom;
        t = f.now;
      end
      pending_frames.push_back(f);
    end
  endtask

  initial begin
    logic [31:0] t;
    regs[REG_THRESHOLD_MULT] = 384;  regs[REG_MIN_RISE] = 0;
    regs[REG_MIN_LEVEL] = 0;         regs[REG_MIN_GAP_MS] = 200;
    regs[REG_INTERVAL_MIN_MS] = 250; regs[REG_INTERVAL_MAX_MS] = 2000;
    regs[REG_STALE_MS] = 3000;       regs[REG_DECAY_STEP] = 164;
    hist_count = 0; hist_head = 0; last_beat_ms = 0; env_level = 0;
    gap_count = 0; gap_head = 0; beat_seen = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: a quiet bed, then a loud frame at time zero, field extremes and wrap.
    for (int i = 0; i < 14; i++) pending_frames.push_back({16'd100, 32'hFFFF_FF00 + i, 10'd1});
    pending_frames.push_back({16'hFFFF, 32'd0, 10'd0});
    pending_frames.push_back({16'd0, 32'd500, 10'h3FF});
    pending_frames.push_back({16'hFFFF, 32'd1000, 10'd0});
    pending_frames.push_back({16'hFFFF, 32'd1500, 10'd2});
    pending_frames.push_back({16'd0, 32'd1600, 10'd1});
    pending_frames.push_back({16'hFFFF, 32'd2100, 10'd0});
    pending_frames.push_back({16'd0, 32'd2200, 10'd0});
    pending_frames.push_back({16'hFFFF, 32'd2700, 10'd0});
    pending_frames.push_back({16'd5, 32'hFFFF_FFFF, 10'd0});
    drain();

    // Pressure: the receiver holds off while frames keep coming.
    t = 10000;
    queue_rhythm(60, t);
    hold_request = 1'b1;
    repeat (5) @(posedge clk);
    hold_request = 1'b0;
    drain();

    for (int phase = 0; phase < 9; phase++) begin
      case (phase % 3)
        0: begin send_idle_pct = 6; recv_idle_pct = 79; end
        1: begin send_idle_pct = 79; recv_idle_pct = 6; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (phase)
        0: write_reg(REG_DECAY_STEP, 16'd32768);
        1: begin
          write_reg(REG_THRESHOLD_MULT, 16'd0);
          write_reg(REG_MIN_GAP_MS, 16'd0);
          write_reg(REG_INTERVAL_MIN_MS, 16'd0);
          write_reg(REG_DECAY_STEP, 16'hFFFF);
        end
        2: begin
          write_reg(REG_THRESHOLD_MULT, 16'hFFFF);
          write_reg(REG_MIN_RISE, 16'hFFFF);
          write_reg(REG_MIN_LEVEL, 16'hFFFF);
        end
        3: begin
          write_reg(REG_THRESHOLD_MULT, 16'd256);
          write_reg(REG_MIN_RISE, 16'd1000);
          write_reg(REG_MIN_LEVEL, 16'd5000);
          write_reg(REG_MIN_GAP_MS, 16'd100);
          write_reg(REG_INTERVAL_MAX_MS, 16'hFFFF);
          write_reg(REG_STALE_MS, 16'hFFFF);
          write_reg(REG_DECAY_STEP, 16'd0);
        end
        4: begin
          write_reg(REG_STALE_MS, 16'd0);
          write_reg(REG_INTERVAL_MAX_MS, 16'd0);
        end
        5: begin
          write_reg(REG_MIN_GAP_MS, 16'hFFFF);
          write_reg(REG_INTERVAL_MIN_MS, 16'hFFFF);
          write_reg(REG_MIN_RISE, 16'd0);
        end
        default: begin
          write_reg(REG_THRESHOLD_MULT, 16'($urandom_range(256, 1024)));
          write_reg(REG_MIN_RISE, 16'($urandom_range(0, 4000)));
          write_reg(REG_MIN_LEVEL, 16'($urandom_range(0, 8000)));
          write_reg(REG_MIN_GAP_MS, 16'($urandom_range(0, 300)));
          write_reg(REG_INTERVAL_MIN_MS, 16'($urandom_range(0, 300)));
          write_reg(REG_INTERVAL_MAX_MS, 16'($urandom_range(500, 65535)));
          write_reg(REG_STALE_MS, 16'($urandom_range(1000, 65535)));
          write_reg(REG_DECAY_STEP, 16'($urandom_range(0, 500)));
        end
      endcase
      queue_rhythm(150, t);
      drain();
    end

    if (errors == 0) begin
      $display("[audio_beat_tempo_detector] OK");
    end else begin
      $display("[audio_beat_tempo_detector] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/abtd_pkg.sv
rtl/core/audio_beat_tempo_detector.sv
rtl/core/abtd_checker.sv
dv/audio_beat_tempo_detector_test.sv
